FILE: hdl/fhs_pkg.sv
// Shared types, constants and helper functions for the fire heat simulation unit.
package fhs_pkg;

    typedef logic [7:0] fhs_heat_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } fhs_rgb_t;

    typedef struct packed {
        logic busy;
        logic done;
    } fhs_div_stat_t;

    // configuration register indexes
    localparam logic [1:0] REG_COOLING = 2'd0;
    localparam logic [1:0] REG_SPARK   = 2'd1;
    localparam logic [1:0] REG_MIRROR  = 2'd2;
    localparam logic [1:0] REG_LENGTH  = 2'd3;

    localparam logic [7:0] COOLING_RST = 8'd50;
    localparam logic [7:0] SPARK_RST   = 8'd120;
    localparam logic [6:0] LENGTH_RST  = 7'd64;

    localparam logic [7:0] SPARK_BASE  = 8'd160;
    localparam logic [7:0] SPARK_MOD   = 8'd95;
    localparam logic [7:0] HEAT_MAX    = 8'd255;
    localparam logic [15:0] COOL_MUL   = 16'd10;
    localparam logic [7:0] COOL_BIAS   = 8'd2;
    localparam logic [15:0] SCALE_MUL  = 16'd191;
    localparam logic [20:0] THIRD_MUL  = 21'd683;   // 683/2048 ~ 1/3, exact for s <= 765

    function automatic fhs_heat_t div3(input logic [9:0] s);
        logic [20:0] p;
        p = 21'(s) * THIRD_MUL;
        return p[18:11];
    endfunction

    // value below 256 is under three times the modulus: two compare-subtracts
    function automatic logic [7:0] mod95(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (r >= SPARK_MOD)
        begin
            r = r - SPARK_MOD;
        end
        if (r >= SPARK_MOD)
        begin
            r = r - SPARK_MOD;
        end
        return r;
    endfunction

    function automatic fhs_rgb_t heat_to_rgb(input fhs_heat_t h);
        logic [15:0] prod;
        logic [7:0]  t;
        logic [7:0]  ramp;
        fhs_rgb_t    c;
        prod = 16'(h) * SCALE_MUL;
        t    = prod[15:8] + {7'd0, (h != 8'd0)};
        ramp = {t[5:0], 2'b00};
        if (t[7])
        begin
            c = '{red: HEAT_MAX, green: HEAT_MAX, blue: ramp};
        end
        else if (t[6])
        begin
            c = '{red: HEAT_MAX, green: ramp, blue: 8'd0};
        end
        else
        begin
            c = '{red: ramp, green: 8'd0, blue: 8'd0};
        end
        return c;
    endfunction

endpackage

FILE: hdl/fhs_cell.sv
// One heat cell of the rotating ring: holds a heat value and takes its neighbor's on a shift.
module fhs_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             shift,
    input  fhs_pkg::fhs_heat_t din,
    output fhs_pkg::fhs_heat_t dout
);
    import fhs_pkg::*;

    fhs_heat_t heat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heat_reg <= '0;
        end
        else if (shift)
        begin
            heat_reg <= din;
        end
    end

    assign dout = heat_reg;

endmodule

FILE: hdl/fhs_divu.sv
// Restoring divider, one quotient bit per cycle, 8-bit divisor.
module fhs_divu #(
    parameter int DW = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [DW-1:0]          dividend,
    input  logic [7:0]             divisor,
    output fhs_pkg::fhs_div_stat_t stat,
    output logic [DW-1:0]          quotient,
    output logic [7:0]             remainder
);
    import fhs_pkg::*;

    localparam int CNTW = $clog2(DW + 1);

    logic [CNTW-1:0] cnt_reg;
    logic            done_reg;
    logic [DW-1:0]   quo_reg;
    logic [DW-1:0]   quo_next;
    logic [7:0]      rem_reg;
    logic [7:0]      rem_next;
    logic [7:0]      dsr_reg;
    logic [8:0]      trial;
    logic            busy;

    assign busy  = (cnt_reg != '0);
    assign trial = {rem_reg, quo_reg[DW-1]};

    always_comb
    begin
        if (trial >= {1'b0, dsr_reg})
        begin
            rem_next = 8'(trial - {1'b0, dsr_reg});
            quo_next = {quo_reg[DW-2:0], 1'b1};
        end
        else
        begin
            rem_next = trial[7:0];
            quo_next = {quo_reg[DW-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == CNTW'(1));
            if (start)
            begin
                cnt_reg <= CNTW'(DW);
            end
            else if (busy)
            begin
                cnt_reg <= cnt_reg - CNTW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign stat.busy = busy;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

FILE: hdl/fire_heat_simulation_unit.sv
// Top level: config registers, sequencer, heat cell ring and pixel output stage.
//
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------------------------
//  in       | in_valid / in_ready  | random_word
//  out      | out_valid / out_ready| pixel_index, pixel_red/green/blue, frame_last
//  cfg      | cfg_write            | cfg_index, cfg_data
//
// One word at a time. A cooling word runs the shared divider for the cooling factor, then the
// four byte remainder lanes, then one full turn of the cell ring. A spark word runs the divider
// for the spark position, then one ring turn emitting a pixel per active cell.
// Reset clears all heat cells and the frame position; registers take their defaults.
// While the output register holds an untaken pixel a spark word's ring freezes on the next active cell.
module fire_heat_simulation_unit #(
    parameter int MAX_CELLS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] random_word,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [5:0]  pixel_index,
    output logic [7:0]  pixel_red,
    output logic [7:0]  pixel_green,
    output logic [7:0]  pixel_blue,
    output logic        frame_last
);
    import fhs_pkg::*;

    localparam int CW = $clog2(MAX_CELLS);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_MOD  = 2'd2;
    localparam logic [1:0] ST_ROT  = 2'd3;

    // configuration
    logic [7:0] cooling_rate_reg;
    logic [7:0] spark_chance_reg;
    logic       mirror_output_reg;
    logic [6:0] strip_length_reg;
    logic [6:0] len;

    // control
    logic [1:0]    state_reg;
    logic [1:0]    state_next;
    logic [CW-1:0] head_reg;
    logic          spark_phase_reg;
    logic [6:0]    cool_idx_reg;
    logic          spark_mode_reg;
    logic [6:0]    cool_base_reg;
    logic [2:0]    cool_cnt_reg;
    logic [31:0]   word_reg;
    logic          cf_zero_reg;
    fhs_heat_t     prev1_reg;
    fhs_heat_t     prev2_reg;

    // output stage
    logic          out_valid_reg;
    fhs_heat_t     out_heat_reg;
    logic [5:0]    out_index_reg;
    logic          out_last_reg;

    logic          in_accept;
    logic          spark_sel;
    logic [2:0]    cool_cnt;
    logic [6:0]    cool_end;

    // divider and lanes
    fhs_div_stat_t div_stat;
    logic [15:0]   div_dividend;
    logic [15:0]   div_quo;
    logic [7:0]    div_rem;
    logic [7:0]    cf;
    logic          lane_start;
    fhs_div_stat_t lane_stat [4];
    logic [7:0]    lane_rem  [4];
    logic          lanes_done;

    // ring
    fhs_heat_t cell_q [MAX_CELLS];
    fhs_heat_t cell_d [MAX_CELLS];
    fhs_heat_t head_old;
    fhs_heat_t head_new;
    fhs_heat_t diffused;
    fhs_heat_t cooled_val;
    fhs_heat_t sparked;
    fhs_heat_t cool_amt;
    logic [8:0] spark_sum;
    logic [6:0] head_ext;
    logic [6:0] cool_off;
    logic       head_active;
    logic       head_cooled;
    logic       spark_hit;
    logic [7:0] spark_add;
    logic       advance;
    logic       load_out;
    logic       last_step;
    logic [6:0] mirror_pos;
    fhs_rgb_t   rgb;

    always_comb
    begin
        if (strip_length_reg == 7'd0)
        begin
            len = 7'd1;
        end
        else if (strip_length_reg > 7'(MAX_CELLS))
        begin
            len = 7'(MAX_CELLS);
        end
        else
        begin
            len = strip_length_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cooling_rate_reg  <= COOLING_RST;
            spark_chance_reg  <= SPARK_RST;
            mirror_output_reg <= 1'b0;
            strip_length_reg  <= LENGTH_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_COOLING: cooling_rate_reg  <= cfg_data;
                REG_SPARK:   spark_chance_reg  <= cfg_data;
                REG_MIRROR:  mirror_output_reg <= cfg_data[0];
                REG_LENGTH:  strip_length_reg  <= cfg_data[6:0];
            endcase
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_accept = in_valid && in_ready;
    assign spark_sel = spark_phase_reg || (cool_idx_reg >= len);

    // cells cooled by this word: one per byte while the rest of the word is nonzero and the cell is within the strip
    always_comb
    begin
        cool_cnt = 3'd1;
        for (int j = 1; j < 4; j++)
        begin
            if (((random_word >> (8 * j)) != 32'd0) &&
                ((8'(cool_idx_reg) + 8'(j)) < 8'(len)))
            begin
                cool_cnt = cool_cnt + 3'd1;
            end
        end
    end
    assign cool_end = cool_idx_reg + 7'(cool_cnt);

    assign div_dividend = spark_sel ? random_word[23:8] : (16'(cooling_rate_reg) * COOL_MUL);

    fhs_divu #(.DW(16)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_accept),
        .dividend  (div_dividend),
        .divisor   (8'(len)),
        .stat      (div_stat),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign cf         = div_quo[7:0] + COOL_BIAS;
    assign lane_start = (state_reg == ST_DIV) && div_stat.done && !spark_mode_reg;

    for (genvar j = 0; j < 4; j++)
    begin : g_lane
        fhs_divu #(.DW(8)) u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .start     (lane_start),
            .dividend  (word_reg[8*j +: 8]),
            .divisor   (cf),
            .stat      (lane_stat[j]),
            .quotient  (),
            .remainder (lane_rem[j])
        );
    end

    always_comb
    begin
        lanes_done = 1'b1;
        for (int j = 0; j < 4; j++)
        begin
            lanes_done = lanes_done && lane_stat[j].done;
        end
    end

    // ring of cells; position 0 is the head, the processed value re-enters at the tail
    for (genvar k = 0; k < MAX_CELLS; k++)
    begin : g_cell
        if (k == MAX_CELLS - 1)
        begin : g_tail
            assign cell_d[k] = head_new;
        end
        else
        begin : g_body
            assign cell_d[k] = cell_q[k+1];
        end
        fhs_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .shift (advance),
            .din   (cell_d[k]),
            .dout  (cell_q[k])
        );
    end

    assign head_old    = cell_q[0];
    assign head_ext    = 7'(head_reg);
    assign head_active = (head_ext < len);
    assign cool_off    = head_ext - cool_base_reg;
    assign head_cooled = (head_ext >= cool_base_reg) && (cool_off < 7'(cool_cnt_reg));
    assign cool_amt    = cf_zero_reg ? word_reg[8*cool_off[1:0] +: 8] : lane_rem[cool_off[1:0]];
    assign cooled_val  = (head_cooled && (head_old > cool_amt)) ? (head_old - cool_amt) :
                         (head_cooled ? 8'd0 : head_old);

    // diffusion uses the unmodified heat of the two cells below
    assign diffused  = ((head_ext >= 7'd2) && head_active) ?
                       div3(10'(prev1_reg) + {1'b0, prev2_reg, 1'b0}) : head_old;
    assign spark_hit = (word_reg[7:0] < spark_chance_reg) && (8'(head_reg) == div_rem);
    assign spark_add = SPARK_BASE + mod95(word_reg[31:24]);
    assign spark_sum = 9'(diffused) + 9'(spark_add);
    assign sparked   = spark_hit ? (spark_sum[8] ? HEAT_MAX : spark_sum[7:0]) : diffused;
    assign head_new  = spark_mode_reg ? sparked : cooled_val;

    assign advance   = (state_reg == ST_ROT) &&
                       (!spark_mode_reg || !head_active || !out_valid_reg || out_ready);
    assign load_out  = advance && spark_mode_reg && head_active;
    assign last_step = advance && (head_reg == CW'(MAX_CELLS - 1));
    assign mirror_pos = len - 7'd1 - head_ext;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = spark_mode_reg ? ST_ROT : ST_MOD;
                end
            end
            ST_MOD:
            begin
                if (lanes_done)
                begin
                    state_next = ST_ROT;
                end
            end
            ST_ROT:
            begin
                if (last_step)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            head_reg        <= '0;
            spark_phase_reg <= 1'b0;
            cool_idx_reg    <= '0;
            spark_mode_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_accept)
            begin
                spark_mode_reg <= spark_sel;
                if (spark_sel)
                begin
                    spark_phase_reg <= 1'b0;
                    cool_idx_reg    <= '0;
                end
                else
                begin
                    cool_idx_reg    <= cool_end;
                    spark_phase_reg <= (cool_end >= len);
                end
            end
            if (last_step)
            begin
                head_reg <= '0;
            end
            else if (advance)
            begin
                head_reg <= head_reg + CW'(1);
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            word_reg      <= random_word;
            cool_base_reg <= cool_idx_reg;
            cool_cnt_reg  <= cool_cnt;
        end
        if (lane_start)
        begin
            cf_zero_reg <= (cf == 8'd0);
        end
        if (advance)
        begin
            prev2_reg <= prev1_reg;
            prev1_reg <= head_old;
        end
        if (load_out)
        begin
            out_heat_reg  <= head_new;
            out_index_reg <= mirror_output_reg ? mirror_pos[5:0] : head_ext[5:0];
            out_last_reg  <= (head_ext == (len - 7'd1));
        end
    end

    assign rgb         = heat_to_rgb(out_heat_reg);
    assign out_valid   = out_valid_reg;
    assign pixel_index = out_index_reg;
    assign pixel_red   = rgb.red;
    assign pixel_green = rgb.green;
    assign pixel_blue  = rgb.blue;
    assign frame_last  = out_last_reg;

    a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside its wait state");

    a_lane_in_mod: assert property (@(posedge clk) disable iff (!rst_n)
        lane_stat[0].done |-> (state_reg == ST_MOD))
        else $error("remainder lanes finished outside their wait state");

    a_idle_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (head_reg == '0))
        else $error("ring not realigned when idle");

    a_no_pixel_cooling: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_ROT) && !spark_mode_reg) |=> !$rose(out_valid_reg))
        else $error("pixel produced by a cooling word");

    a_cool_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        cool_idx_reg <= 7'(MAX_CELLS + 3))
        else $error("cooling position out of range");

endmodule
